### rtl/sosmu_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the SOS interface Metropolis update block.
// No dependencies; used by sos_interface_metropolis_update.
package sosmu_pkg;

    // Default geometry
    localparam int RING_SIZE_DEF   = 256;
    localparam int HEIGHT_BITS_DEF = 6;

    // Fixed field widths
    localparam int SITE_BITS      = 8;
    localparam int DRAW_BITS      = 16;
    localparam int PROB_BITS      = 17;
    localparam int LIMIT_BITS     = 7;
    localparam int CFG_INDEX_BITS = 3;

    // Column height after reset (clamped to the height range)
    localparam int START_HEIGHT = 20;

    // Register reset values
    localparam logic [PROB_BITS-1:0]  RST_UP_DROP2   = 17'd65536;
    localparam logic [PROB_BITS-1:0]  RST_UP_FLAT    = 17'd27146;
    localparam logic [PROB_BITS-1:0]  RST_UP_RISE2   = 17'd11247;
    localparam logic [PROB_BITS-1:0]  RST_DOWN_DROP2 = 17'd65536;
    localparam logic [PROB_BITS-1:0]  RST_DOWN_FLAT  = 17'd65536;
    localparam logic [PROB_BITS-1:0]  RST_DOWN_RISE2 = 17'd65536;
    localparam logic [LIMIT_BITS-1:0] RST_LIMIT      = 7'd40;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_UP_DROP2   = 3'd0,
        CFG_UP_FLAT    = 3'd1,
        CFG_UP_RISE2   = 3'd2,
        CFG_DOWN_DROP2 = 3'd3,
        CFG_DOWN_FLAT  = 3'd4,
        CFG_DOWN_RISE2 = 3'd5,
        CFG_LIMIT      = 3'd6
    } cfg_index_t;

    // Count of neighbours whose bond grows with the move: 0, 1 or 2
    typedef enum logic [1:0] {
        DE_DROP2 = 2'd0,
        DE_FLAT  = 2'd1,
        DE_RISE2 = 2'd2
    } de_class_t;

    // Block control
    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

endpackage

### rtl/sos_interface_metropolis_update.sv
`timescale 1ns / 1ps
// Top level: Metropolis update of a 1-D solid-on-solid interface ring.
// Depends on sosmu_pkg (widths, reset values, register and state codes).
//
// Proposal channel (prop_valid/prop_ready): site, direction, random_draw.
// Result channel (res_valid/res_ready): accepted, site_out, new_height,
// exactly one result per proposal, in order.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; unknown indexes are dropped. Write only while idle.
// Pipeline: a proposal transfer loads the input stage and the three height
// reads (site, left, right); the result register loads from the input stage
// when the output is free, and res_valid rises with it. One proposal per cycle
// sustained while res_ready stays high: the height store is three copies of a
// one-read, one-write RAM, and the write of the item in the input stage is
// forwarded into the reads of the next one.
// Reset: config registers take their reset values at once. The heights are
// then cleared to the start height by a pass over all RING_SIZE columns, one
// column a cycle; prop_ready stays low until it ends.
// Stall: while the result waits, one more proposal is taken into the input
// stage; after that prop_ready drops until res_ready frees the output.
module sos_interface_metropolis_update #(
    parameter int RING_SIZE   = sosmu_pkg::RING_SIZE_DEF,
    parameter int HEIGHT_BITS = sosmu_pkg::HEIGHT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // proposal channel
    input  logic                               prop_valid,
    output logic                               prop_ready,
    input  logic [sosmu_pkg::SITE_BITS-1:0]    site,
    input  logic                               direction,
    input  logic [sosmu_pkg::DRAW_BITS-1:0]    random_draw,
    // result channel
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic                               accepted,
    output logic [sosmu_pkg::SITE_BITS-1:0]    site_out,
    output logic [HEIGHT_BITS-1:0]             new_height,
    // configuration channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sosmu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sosmu_pkg::PROB_BITS-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(RING_SIZE);
    localparam int CMP_W  = (HEIGHT_BITS > sosmu_pkg::LIMIT_BITS) ?
                            HEIGHT_BITS : sosmu_pkg::LIMIT_BITS;
    localparam int HMAX   = (1 << HEIGHT_BITS) - 1;
    localparam logic [HEIGHT_BITS-1:0] START_H =
        HEIGHT_BITS'((sosmu_pkg::START_HEIGHT > HMAX) ? HMAX : sosmu_pkg::START_HEIGHT);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(RING_SIZE - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [sosmu_pkg::PROB_BITS-1:0]  up_drop2_reg, up_flat_reg, up_rise2_reg;
    logic [sosmu_pkg::PROB_BITS-1:0]  down_drop2_reg, down_flat_reg, down_rise2_reg;
    logic [sosmu_pkg::LIMIT_BITS-1:0] limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_drop2_reg   <= sosmu_pkg::RST_UP_DROP2;
            up_flat_reg    <= sosmu_pkg::RST_UP_FLAT;
            up_rise2_reg   <= sosmu_pkg::RST_UP_RISE2;
            down_drop2_reg <= sosmu_pkg::RST_DOWN_DROP2;
            down_flat_reg  <= sosmu_pkg::RST_DOWN_FLAT;
            down_rise2_reg <= sosmu_pkg::RST_DOWN_RISE2;
            limit_reg      <= sosmu_pkg::RST_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sosmu_pkg::CFG_UP_DROP2:   up_drop2_reg   <= cfg_data;
                sosmu_pkg::CFG_UP_FLAT:    up_flat_reg    <= cfg_data;
                sosmu_pkg::CFG_UP_RISE2:   up_rise2_reg   <= cfg_data;
                sosmu_pkg::CFG_DOWN_DROP2: down_drop2_reg <= cfg_data;
                sosmu_pkg::CFG_DOWN_FLAT:  down_flat_reg  <= cfg_data;
                sosmu_pkg::CFG_DOWN_RISE2: down_rise2_reg <= cfg_data;
                sosmu_pkg::CFG_LIMIT:
                    limit_reg <= cfg_data[sosmu_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control: clearing pass after reset, then run
    // ------------------------------------------------------------------
    sosmu_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clearing;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sosmu_pkg::ST_CLEAR:
                if (clr_cnt_reg == LAST_IDX)
                    state_next = sosmu_pkg::ST_RUN;
            sosmu_pkg::ST_RUN:
                state_next = sosmu_pkg::ST_RUN;
            default:
                state_next = sosmu_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        clearing = 1'b0;
        case (state_reg)
            sosmu_pkg::ST_CLEAR: clearing = 1'b1;
            sosmu_pkg::ST_RUN:   clearing = 1'b0;
            default:             clearing = 1'b1;
        endcase
    end

    assign clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sosmu_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake and stage control
    // ------------------------------------------------------------------
    logic s1_valid_reg, res_valid_reg;
    logic s1_advance, prop_fire;

    assign s1_advance = !res_valid_reg || res_ready;
    assign prop_ready = !clearing && (!s1_valid_reg || s1_advance);
    assign prop_fire  = prop_valid && prop_ready;

    // ------------------------------------------------------------------
    // Read addresses of the incoming proposal (center, left, right)
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] rd_c, rd_l, rd_r;
    logic              in_ring;

    assign in_ring = (32'(site) < RING_SIZE);
    assign rd_c    = ADDR_W'(site);
    assign rd_r    = (rd_c == LAST_IDX) ? '0 : rd_c + 1'b1;
    assign rd_l    = (rd_c == '0) ? LAST_IDX : rd_c - 1'b1;

    // ------------------------------------------------------------------
    // Input stage registers
    // ------------------------------------------------------------------
    logic [sosmu_pkg::SITE_BITS-1:0] s1_site_reg;
    logic [sosmu_pkg::DRAW_BITS-1:0] s1_draw_reg;
    logic [ADDR_W-1:0]               s1_idx_reg;
    logic                            s1_up_reg, s1_in_ring_reg;
    logic [HEIGHT_BITS-1:0]          h_c_reg, h_l_reg, h_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (prop_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (prop_fire)
        begin
            s1_site_reg    <= site;
            s1_draw_reg    <= random_draw;
            s1_idx_reg     <= rd_c;
            s1_up_reg      <= direction;
            s1_in_ring_reg <= in_ring;
        end
    end

    // ------------------------------------------------------------------
    // Height store: three identical copies, one read port each
    // ------------------------------------------------------------------
    logic [HEIGHT_BITS-1:0] mem_c [RING_SIZE];
    logic [HEIGHT_BITS-1:0] mem_l [RING_SIZE];
    logic [HEIGHT_BITS-1:0] mem_r [RING_SIZE];

    logic                   mem_we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [HEIGHT_BITS-1:0] wr_data;
    logic                   move_ok;
    logic [HEIGHT_BITS-1:0] h2;

    assign mem_we  = clearing || (s1_valid_reg && s1_advance && move_ok);
    assign wr_addr = clearing ? clr_cnt_reg : s1_idx_reg;
    assign wr_data = clearing ? START_H : h2;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_c[wr_addr] <= wr_data;
            mem_l[wr_addr] <= wr_data;
            mem_r[wr_addr] <= wr_data;
        end
        if (prop_fire)
        begin
            // same-edge write from the item ahead is forwarded
            h_c_reg <= (mem_we && wr_addr == rd_c) ? wr_data : mem_c[rd_c];
            h_l_reg <= (mem_we && wr_addr == rd_l) ? wr_data : mem_l[rd_l];
            h_r_reg <= (mem_we && wr_addr == rd_r) ? wr_data : mem_r[rd_r];
        end
    end

    // ------------------------------------------------------------------
    // Move evaluation
    // ------------------------------------------------------------------
    logic                            room, below_limit, grow_l, grow_r;
    logic [1:0]                      grow_cnt;
    logic [sosmu_pkg::PROB_BITS-1:0] thr;
    logic [HEIGHT_BITS-1:0]          result_h;

    assign h2   = s1_up_reg ? h_c_reg + 1'b1 : h_c_reg - 1'b1;
    assign room = s1_up_reg ? !(&h_c_reg) : (h_c_reg != '0);
    assign below_limit = CMP_W'(h2) < CMP_W'(limit_reg);

    // a bond grows by one when the neighbour is on the far side of the move
    assign grow_l   = s1_up_reg ? (h_l_reg <= h_c_reg) : (h_l_reg >= h_c_reg);
    assign grow_r   = s1_up_reg ? (h_r_reg <= h_c_reg) : (h_r_reg >= h_c_reg);
    assign grow_cnt = {1'b0, grow_l} + {1'b0, grow_r};

    always_comb
    begin
        case (grow_cnt)
            sosmu_pkg::DE_DROP2: thr = s1_up_reg ? up_drop2_reg : down_drop2_reg;
            sosmu_pkg::DE_FLAT:  thr = s1_up_reg ? up_flat_reg  : down_flat_reg;
            sosmu_pkg::DE_RISE2: thr = s1_up_reg ? up_rise2_reg : down_rise2_reg;
            default:             thr = s1_up_reg ? up_rise2_reg : down_rise2_reg;
        endcase
    end

    assign move_ok  = s1_in_ring_reg && room && below_limit && (thr > {1'b0, s1_draw_reg});
    assign result_h = !s1_in_ring_reg ? '0 : (move_ok ? h2 : h_c_reg);

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                            accepted_reg;
    logic [sosmu_pkg::SITE_BITS-1:0] site_out_reg;
    logic [HEIGHT_BITS-1:0]          new_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (s1_advance)
            res_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            accepted_reg   <= move_ok;
            site_out_reg   <= s1_site_reg;
            new_height_reg <= result_h;
        end
    end

    assign res_valid  = res_valid_reg;
    assign accepted   = accepted_reg;
    assign site_out   = site_out_reg;
    assign new_height = new_height_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_take_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !prop_ready)
        else $error("proposal taken during clearing pass");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && res_valid_reg && !res_ready |-> !prop_ready)
        else $error("input stage overwritten while output stalled");

    a_transfer_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        prop_fire |=> s1_valid_reg)
        else $error("transfer did not load input stage");

    a_out_of_ring_refused: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (32'(site_out_reg) >= RING_SIZE) |->
            !accepted_reg && (new_height_reg == '0))
        else $error("site outside ring not refused");

endmodule

### verif/sosmu_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the SOS interface Metropolis update testbench: a move predictor
// with its own height ring and register copies, and the in-order result check.
// Depends on sosmu_pkg.
package sosmu_tb_pkg;

    localparam int RING  = sosmu_pkg::RING_SIZE_DEF;
    localparam int HBITS = sosmu_pkg::HEIGHT_BITS_DEF;
    localparam int HMAX  = (1 << HBITS) - 1;

    typedef struct packed {
        logic                            accepted;
        logic [sosmu_pkg::SITE_BITS-1:0] site;
        logic [HBITS-1:0]                height;
    } move_result_t;

    class metropolis_scoreboard;
        logic [sosmu_pkg::PROB_BITS-1:0]  up_prob [3];
        logic [sosmu_pkg::PROB_BITS-1:0]  down_prob [3];
        logic [sosmu_pkg::LIMIT_BITS-1:0] limit;
        logic [HBITS-1:0]                 column_h [RING];
        move_result_t                     expected_moves [$];
        int                               errors;
        int                               moves;
        int                               accepts;

        function new();
            int start;
            start = (sosmu_pkg::START_HEIGHT > HMAX) ? HMAX : sosmu_pkg::START_HEIGHT;
            foreach (column_h[i])
                column_h[i] = HBITS'(start);
            up_prob[sosmu_pkg::DE_DROP2]   = sosmu_pkg::RST_UP_DROP2;
            up_prob[sosmu_pkg::DE_FLAT]    = sosmu_pkg::RST_UP_FLAT;
            up_prob[sosmu_pkg::DE_RISE2]   = sosmu_pkg::RST_UP_RISE2;
            down_prob[sosmu_pkg::DE_DROP2] = sosmu_pkg::RST_DOWN_DROP2;
            down_prob[sosmu_pkg::DE_FLAT]  = sosmu_pkg::RST_DOWN_FLAT;
            down_prob[sosmu_pkg::DE_RISE2] = sosmu_pkg::RST_DOWN_RISE2;
            limit   = sosmu_pkg::RST_LIMIT;
            errors  = 0;
            moves   = 0;
            accepts = 0;
        endfunction

        function void load_register(logic [sosmu_pkg::CFG_INDEX_BITS-1:0] idx,
                                    logic [sosmu_pkg::PROB_BITS-1:0] data);
            case (idx)
                sosmu_pkg::CFG_UP_DROP2:   up_prob[sosmu_pkg::DE_DROP2]   = data;
                sosmu_pkg::CFG_UP_FLAT:    up_prob[sosmu_pkg::DE_FLAT]    = data;
                sosmu_pkg::CFG_UP_RISE2:   up_prob[sosmu_pkg::DE_RISE2]   = data;
                sosmu_pkg::CFG_DOWN_DROP2: down_prob[sosmu_pkg::DE_DROP2] = data;
                sosmu_pkg::CFG_DOWN_FLAT:  down_prob[sosmu_pkg::DE_FLAT]  = data;
                sosmu_pkg::CFG_DOWN_RISE2: down_prob[sosmu_pkg::DE_RISE2] = data;
                sosmu_pkg::CFG_LIMIT:      limit = data[sosmu_pkg::LIMIT_BITS-1:0];
                default:                   ;
            endcase
        endfunction

        function int gap_abs(int a, int b);
            return (a > b) ? a - b : b - a;
        endfunction

        // Site is 8 bits on a 256-column ring, so every site is on the ring.
        function void note_proposal(logic [sosmu_pkg::SITE_BITS-1:0] s, logic up,
                                    logic [sosmu_pkg::DRAW_BITS-1:0] draw);
            int                              h;
            int                              hl;
            int                              hr;
            int                              h2;
            int                              de;
            sosmu_pkg::de_class_t            cls;
            logic [sosmu_pkg::PROB_BITS-1:0] thr;
            move_result_t                    r;
            h  = column_h[s];
            hl = column_h[(int'(s) + RING - 1) % RING];
            hr = column_h[(int'(s) + 1) % RING];
            h2 = up ? h + 1 : h - 1;
            r.accepted = 1'b0;
            r.site     = s;
            r.height   = HBITS'(h);
            moves++;
            if (h2 >= 0 && h2 < int'(limit) && h2 <= HMAX) begin
                de  = gap_abs(h2, hl) + gap_abs(h2, hr) - gap_abs(h, hl) - gap_abs(h, hr);
                cls = (de < 0) ? sosmu_pkg::DE_DROP2 :
                      (de == 0) ? sosmu_pkg::DE_FLAT : sosmu_pkg::DE_RISE2;
                thr = up ? up_prob[cls] : down_prob[cls];
                if (thr > {1'b0, draw}) begin
                    column_h[s] = HBITS'(h2);
                    r.accepted  = 1'b1;
                    r.height    = HBITS'(h2);
                    accepts++;
                end
            end
            expected_moves.push_back(r);
        endfunction

        function void check_result(logic acc, logic [sosmu_pkg::SITE_BITS-1:0] s,
                                   logic [HBITS-1:0] hgt);
            move_result_t e;
            if (expected_moves.size() == 0) begin
                errors++;
                $display("%0t: result for site %0d with nothing expected", $time, s);
                return;
            end
            e = expected_moves.pop_front();
            if (acc !== e.accepted) begin
                errors++;
                $display("%0t: accepted expected %0d actual %0d (site %0d)",
                         $time, e.accepted, acc, e.site);
            end
            if (s !== e.site) begin
                errors++;
                $display("%0t: site_out expected %0d actual %0d", $time, e.site, s);
            end
            if (hgt !== e.height) begin
                errors++;
                $display("%0t: new_height expected %0d actual %0d (site %0d)",
                         $time, e.height, hgt, e.site);
            end
        endfunction

        function int pending();
            return expected_moves.size();
        endfunction
    endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for sos_interface_metropolis_update: drives proposals and
// register writes, checks every result against a predicted height ring.
// Depends on sosmu_pkg, sosmu_tb_pkg and the block RTL.
module tb_top;

    // Longest legal quiet spell: reset plus the clear pass, or an idle gap on
    // top of a result stall. Taken several times over.
    localparam int WATCHDOG_LIMIT = 3000;
    // Settle time after the drain, in clock cycles
    localparam int SETTLE_CYCLES  = 4;
    localparam logic [sosmu_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 3'd7;
    localparam logic [sosmu_pkg::PROB_BITS-1:0] P_NEVER  = 17'd0;
    localparam logic [sosmu_pkg::PROB_BITS-1:0] P_ALWAYS = 17'd65536;
    localparam logic [sosmu_pkg::PROB_BITS-1:0] P_TOP    = 17'h1FFFF;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 prop_valid;
    logic                                 prop_ready;
    logic [sosmu_pkg::SITE_BITS-1:0]      site;
    logic                                 direction;
    logic [sosmu_pkg::DRAW_BITS-1:0]      random_draw;
    logic                                 res_valid;
    logic                                 res_ready;
    logic                                 accepted;
    logic [sosmu_pkg::SITE_BITS-1:0]      site_out;
    logic [sosmu_tb_pkg::HBITS-1:0]       new_height;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [sosmu_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [sosmu_pkg::PROB_BITS-1:0]      cfg_data;

    sosmu_tb_pkg::metropolis_scoreboard sb;
    bit                   idle_on;
    int                   stall_left   = 0;
    int                   quiet_cycles = 0;
    int                   cfg_writes   = 0;
    int                   settings     = 0;

    sos_interface_metropolis_update u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .prop_valid  (prop_valid),
        .prop_ready  (prop_ready),
        .site        (site),
        .direction   (direction),
        .random_draw (random_draw),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .accepted    (accepted),
        .site_out    (site_out),
        .new_height  (new_height),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result side back-pressure: random stalls while idling is on.
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_on && rst_n && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 17);
        res_ready <= (stall_left == 0);
    end

    // Result check and watchdog. Everything here samples pre-edge values, so the
    // outcome does not depend on process order within the edge.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(accepted, site_out, new_height);
        if ((prop_valid && prop_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, sb.pending());
            $display("tb_top: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One proposal transfer. Valid is only dropped at the start of an idle gap,
    // so back-to-back proposals keep it high without a low glitch.
    task automatic send_move(input logic [sosmu_pkg::SITE_BITS-1:0] s, input logic up,
                             input logic [sosmu_pkg::DRAW_BITS-1:0] draw);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            prop_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        prop_valid  <= 1'b1;
        site        <= s;
        direction   <= up;
        random_draw <= draw;
        do @(posedge clk); while (!prop_ready);
        sb.note_proposal(s, up, draw);
    endtask

    // Drain all outstanding results; registers may only change when idle.
    task automatic wait_idle();
        prop_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sosmu_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [sosmu_pkg::PROB_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.load_register(idx, data);
        cfg_writes++;
    endtask

    // Full register set; junk goes in the upper bits of the limit write and
    // one write goes to the unused index, which must be dropped.
    task automatic apply_setting(input logic [sosmu_pkg::PROB_BITS-1:0] up_d, up_f, up_r,
                                 input logic [sosmu_pkg::PROB_BITS-1:0] dn_d, dn_f, dn_r,
                                 input logic [sosmu_pkg::LIMIT_BITS-1:0] lim);
        wait_idle();
        write_reg(sosmu_pkg::CFG_UP_DROP2, up_d);
        write_reg(sosmu_pkg::CFG_UP_FLAT, up_f);
        write_reg(sosmu_pkg::CFG_UP_RISE2, up_r);
        write_reg(sosmu_pkg::CFG_DOWN_DROP2, dn_d);
        write_reg(sosmu_pkg::CFG_DOWN_FLAT, dn_f);
        write_reg(sosmu_pkg::CFG_DOWN_RISE2, dn_r);
        write_reg(sosmu_pkg::CFG_LIMIT, {10'($urandom), lim});
        write_reg(CFG_UNUSED, 17'($urandom));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Draws: extremes, values sitting right on a live threshold, and uniform.
    function automatic logic [sosmu_pkg::DRAW_BITS-1:0] pick_draw();
        logic [sosmu_pkg::PROB_BITS-1:0] p;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2:
            begin
                p = ($urandom_range(0, 1) == 1) ? sb.up_prob[$urandom_range(0, 2)]
                                                : sb.down_prob[$urandom_range(0, 2)];
                // draw equal to threshold is refused, one below it is taken
                return sosmu_pkg::DRAW_BITS'(p - $urandom_range(0, 1));
            end
            default: return sosmu_pkg::DRAW_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [sosmu_pkg::PROB_BITS-1:0] pick_prob();
        case ($urandom_range(0, 4))
            0: return P_NEVER;
            1: return P_ALWAYS;
            2: return P_TOP;
            default: return sosmu_pkg::PROB_BITS'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [sosmu_pkg::LIMIT_BITS-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return sosmu_pkg::LIMIT_BITS'($urandom_range(1, 63));
            1: return sosmu_pkg::LIMIT_BITS'($urandom_range(64, 127));
            default: return sosmu_pkg::LIMIT_BITS'($urandom_range(20, 45));
        endcase
    endfunction

    // Most proposals hit a small window of neighboring columns so heights walk
    // far enough to reach the floor, the limit and the 6-bit ceiling; the
    // direction bias sets which way they walk.
    task automatic run_moves(input int count, input int up_pct, input int window);
        int                              base;
        logic [sosmu_pkg::SITE_BITS-1:0] s;
        base = $urandom_range(0, sosmu_tb_pkg::RING - 1);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                s = sosmu_pkg::SITE_BITS'((base + $urandom_range(0, window - 1))
                                          % sosmu_tb_pkg::RING);
            else
                s = sosmu_pkg::SITE_BITS'($urandom);
            send_move(s, $urandom_range(0, 99) < up_pct, pick_draw());
        end
    endtask

    initial
    begin
        sb = new();
        idle_on = 1'b1;
        rst_n       <= 1'b0;
        prop_valid  <= 1'b0;
        site        <= '0;
        direction   <= 1'b0;
        random_draw <= '0;
        res_ready   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset registers: ring wrap at both ends, draw extremes,
        // draws on either side of the reset thresholds, alternating bit patterns.
        send_move(8'd0,   1'b1, 16'd0);
        send_move(8'd255, 1'b1, 16'hFFFF);
        send_move(8'd255, 1'b0, 16'hFFFF);
        send_move(8'd1,   1'b1, 16'd27145);
        send_move(8'd2,   1'b1, 16'd11247);
        send_move(8'd3,   1'b1, 16'd11246);
        send_move(8'd2,   1'b1, 16'd27146);
        send_move(8'd0,   1'b0, 16'd0);
        send_move(8'hAA,  1'b1, 16'hAAAA);
        send_move(8'h55,  1'b0, 16'h5555);
        send_move(8'd128, 1'b1, 16'd1);
        send_move(8'd127, 1'b1, 16'd11246);
        send_move(8'd128, 1'b0, 16'h8000);
        send_move(8'd254, 1'b0, 16'h7FFF);
        send_move(8'd254, 1'b1, 16'd0);
        send_move(8'd255, 1'b1, 16'd0);
        send_move(8'd0,   1'b1, 16'd0);
        send_move(8'd1,   1'b0, 16'hFFFF);

        // Everything accepted, lowering bias: columns hit zero, lowering below zero
        apply_setting(P_ALWAYS, P_ALWAYS, P_ALWAYS, P_ALWAYS, P_ALWAYS, P_ALWAYS, 7'd127);
        run_moves(220, 10, 2);
        // Tiny limit: a move is taken only if it lands below the limit, so columns above it are frozen
        apply_setting(P_ALWAYS, P_ALWAYS, P_ALWAYS, P_ALWAYS, P_ALWAYS, P_ALWAYS, 7'd2);
        run_moves(80, 50, 3);
        // Raising bias with no limit in reach: heights reach the 6-bit ceiling
        apply_setting(P_TOP, P_ALWAYS, P_TOP, P_ALWAYS, P_TOP, P_ALWAYS, 7'd127);
        run_moves(260, 90, 2);
        // Thresholds of zero refuse every draw
        apply_setting(P_NEVER, P_NEVER, P_NEVER, P_NEVER, P_NEVER, P_NEVER, 7'd64);
        run_moves(60, 50, 8);
        // Limit of zero refuses every move
        apply_setting(P_TOP, P_TOP, P_TOP, P_TOP, P_TOP, P_TOP, 7'd0);
        run_moves(60, 50, 8);
        // Limit right at the 6-bit range
        apply_setting(P_ALWAYS, 17'd32768, 17'd16384, P_ALWAYS, 17'd49152, 17'd8192, 7'd64);
        run_moves(100, 70, 3);

        // Random settings; the last one runs with no idling on either side
        for (int ph = 0; ph < 4; ph++)
        begin
            apply_setting(pick_prob(), pick_prob(), pick_prob(),
                          pick_prob(), pick_prob(), pick_prob(), pick_limit());
            idle_on = (ph != 3);
            run_moves(160, $urandom_range(20, 80),
                      ($urandom_range(0, 1) == 1) ? $urandom_range(2, 16)
                                                  : sosmu_tb_pkg::RING);
        end

        wait_idle();
        $display("summary: %0d proposals checked, %0d moves taken", sb.moves, sb.accepts);
        $display("summary: %0d register settings, %0d register writes, %0d mismatches",
                 settings, cfg_writes, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
